// File: src/bmh_pkg.sv
// bmh_pkg: shared constants, codes and control types of the binary max-heap
// used by bmh_ctrl, bmh_dp and binary_max_heap; depends on nothing
package bmh_pkg;

   localparam int DEPTH       = 1024;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int POS_W       = $clog2(DEPTH + 1);
   localparam int KEY_W       = 32;
   localparam int FIELD_W     = 11;
   localparam int CMP_W       = (POS_W > FIELD_W) ? POS_W : FIELD_W;
   localparam int STATUS_W    = 2;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 56;

   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_DELETE = 1'b1
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_DEL_LAST,
      S_DEL_PAR,
      S_UP_RD,
      S_UP_CMP,
      S_DN_RD,
      S_DN_LEFT,
      S_DN_RIGHT,
      S_DONE
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic set_full;
      logic set_bad;
      logic drop_last;
      logic start_ins;
      logic start_del;
      logic load_key;
      logic rd_parent;
      logic rd_left;
      logic rd_right;
      logic save_left;
      logic wr_key_here;
      logic up_move;
      logic dn_move_left;
      logic dn_move_best;
   } dp_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic is_insert;
      logic full;
      logic bad;
      logic del_last;
      logic here_root;
      logic no_child;
      logic has_right;
      logic key_gt_rd;
      logic rd_gt_key;
      logic best_gt_key;
   } dp_sts_type;

endpackage

// File: src/binary_max_heap.sv
// Binary max-heap of signed 32-bit keys, up to 1024 entries at positions 1..count.
// An item that is refused or only drops the last entry needs no sift; an insert
// sifts up and a delete sifts up or down, a level at a time; the single-port key
// memory, one read or write per cycle, sets the pace.
// One item is worked at a time; the result waits in registers until taken.
// No clearing pass after reset: entries are read only once written.
// Top level; depends on bmh_pkg, bmh_ctrl and bmh_dp
module binary_max_heap (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // key_value[31:0], position[42:32], zero fill
   input  logic [bmh_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // req_type[0]
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // final_position[10:0], root_key[42:11], entry_count[53:43], zero fill
   output logic [bmh_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // status[1:0]
   output logic [bmh_pkg::STATUS_W-1:0]        rsp_tuser
);

   bmh_pkg::dp_cmd_type                 cmd;
   bmh_pkg::dp_sts_type                 sts;
   logic signed [bmh_pkg::KEY_W-1:0]    root_key;
   logic        [bmh_pkg::FIELD_W-1:0]  final_position;
   logic        [bmh_pkg::FIELD_W-1:0]  entry_count;

   bmh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bmh_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_kind      (req_tuser),
      .req_key       (req_tdata[bmh_pkg::KEY_W-1:0]),
      .req_pos       (req_tdata[bmh_pkg::KEY_W +: bmh_pkg::FIELD_W]),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_status    (rsp_tuser),
      .rsp_final_pos (final_position),
      .rsp_root      (root_key),
      .rsp_count     (entry_count)
   );

   assign rsp_tdata = {2'b00, entry_count, root_key, final_position};

endmodule

// File: src/bmh_ctrl.sv
// bmh_ctrl: sequencer of the heap operations, at most one memory access per cycle
// depends on bmh_pkg; drives bmh_dp through dp_cmd_type
module bmh_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  bmh_pkg::dp_sts_type sts,
   output bmh_pkg::dp_cmd_type cmd
);

   bmh_pkg::state_type state_ff;
   bmh_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bmh_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bmh_pkg::S_IDLE: begin
            if (req_tvalid) state_in = bmh_pkg::S_CHECK;
         end
         bmh_pkg::S_CHECK: begin
            if (sts.is_insert) begin
               state_in = sts.full ? bmh_pkg::S_DONE : bmh_pkg::S_UP_RD;
            end else if (sts.bad || sts.del_last) begin
               state_in = bmh_pkg::S_DONE;
            end else begin
               state_in = bmh_pkg::S_DEL_LAST;
            end
         end
         bmh_pkg::S_DEL_LAST: begin
            state_in = sts.here_root ? bmh_pkg::S_DN_RD : bmh_pkg::S_DEL_PAR;
         end
         bmh_pkg::S_DEL_PAR: begin
            state_in = sts.key_gt_rd ? bmh_pkg::S_UP_RD : bmh_pkg::S_DN_RD;
         end
         bmh_pkg::S_UP_RD: begin
            state_in = sts.here_root ? bmh_pkg::S_DONE : bmh_pkg::S_UP_CMP;
         end
         bmh_pkg::S_UP_CMP: begin
            state_in = sts.key_gt_rd ? bmh_pkg::S_UP_RD : bmh_pkg::S_DONE;
         end
         bmh_pkg::S_DN_RD: begin
            state_in = sts.no_child ? bmh_pkg::S_DONE : bmh_pkg::S_DN_LEFT;
         end
         bmh_pkg::S_DN_LEFT: begin
            if (sts.has_right) begin
               state_in = bmh_pkg::S_DN_RIGHT;
            end else begin
               state_in = sts.rd_gt_key ? bmh_pkg::S_DN_RD : bmh_pkg::S_DONE;
            end
         end
         bmh_pkg::S_DN_RIGHT: begin
            state_in = sts.best_gt_key ? bmh_pkg::S_DN_RD : bmh_pkg::S_DONE;
         end
         bmh_pkg::S_DONE: begin
            if (rsp_tready) state_in = bmh_pkg::S_IDLE;
         end
         default: state_in = bmh_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         bmh_pkg::S_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         bmh_pkg::S_CHECK: begin
            if (sts.is_insert) begin
               cmd.set_full  = sts.full;
               cmd.start_ins = !sts.full;
            end else if (sts.bad) begin
               cmd.set_bad = 1'b1;
            end else if (sts.del_last) begin
               cmd.drop_last = 1'b1;
            end else begin
               cmd.start_del = 1'b1;
            end
         end
         bmh_pkg::S_DEL_LAST: begin
            cmd.load_key  = 1'b1;
            cmd.rd_parent = !sts.here_root;
         end
         bmh_pkg::S_DEL_PAR: begin
            cmd.up_move = sts.key_gt_rd;
         end
         bmh_pkg::S_UP_RD: begin
            cmd.wr_key_here = sts.here_root;
            cmd.rd_parent   = !sts.here_root;
         end
         bmh_pkg::S_UP_CMP: begin
            cmd.up_move     = sts.key_gt_rd;
            cmd.wr_key_here = !sts.key_gt_rd;
         end
         bmh_pkg::S_DN_RD: begin
            cmd.wr_key_here = sts.no_child;
            cmd.rd_left     = !sts.no_child;
         end
         bmh_pkg::S_DN_LEFT: begin
            if (sts.has_right) begin
               cmd.save_left = 1'b1;
               cmd.rd_right  = 1'b1;
            end else begin
               cmd.dn_move_left = sts.rd_gt_key;
               cmd.wr_key_here  = !sts.rd_gt_key;
            end
         end
         bmh_pkg::S_DN_RIGHT: begin
            cmd.dn_move_best = sts.best_gt_key;
            cmd.wr_key_here  = !sts.best_gt_key;
         end
         bmh_pkg::S_DONE: begin
            rsp_tvalid = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// File: src/bmh_dp.sv
// bmh_dp: heap memory, count, moving key and result registers of the heap
// depends on bmh_pkg; commanded by bmh_ctrl
module bmh_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_kind,
   input  logic signed [bmh_pkg::KEY_W-1:0]     req_key,
   input  logic        [bmh_pkg::FIELD_W-1:0]   req_pos,
   input  bmh_pkg::dp_cmd_type                  cmd,
   output bmh_pkg::dp_sts_type                  sts,
   output logic        [bmh_pkg::STATUS_W-1:0]  rsp_status,
   output logic        [bmh_pkg::FIELD_W-1:0]   rsp_final_pos,
   output logic signed [bmh_pkg::KEY_W-1:0]     rsp_root,
   output logic        [bmh_pkg::FIELD_W-1:0]   rsp_count
);

   logic signed [bmh_pkg::KEY_W-1:0] heap_mem [bmh_pkg::DEPTH];

   logic                               kind_ff;
   logic signed [bmh_pkg::KEY_W-1:0]   key_ff, key_in;
   logic signed [bmh_pkg::KEY_W-1:0]   ckey_ff;
   logic signed [bmh_pkg::KEY_W-1:0]   rdata_ff;
   logic signed [bmh_pkg::KEY_W-1:0]   root_ff;
   logic        [bmh_pkg::FIELD_W-1:0] pos_ff;
   logic        [bmh_pkg::POS_W-1:0]   cnt_ff, cnt_in;
   logic        [bmh_pkg::POS_W-1:0]   here_ff, here_in;
   logic        [bmh_pkg::POS_W-1:0]   settled_ff, settled_in;
   bmh_pkg::status_type                status_ff, status_in;

   logic        [bmh_pkg::POS_W:0]     left_w;
   logic        [bmh_pkg::POS_W-1:0]   left_pos;
   logic        [bmh_pkg::POS_W-1:0]   right_pos;
   logic        [bmh_pkg::POS_W-1:0]   parent_pos;
   logic                               right_gt;
   logic signed [bmh_pkg::KEY_W-1:0]   best_key;
   logic        [bmh_pkg::POS_W-1:0]   best_pos;

   logic                               mem_we;
   logic                               mem_re;
   logic        [bmh_pkg::POS_W-1:0]   mem_pos;
   logic        [bmh_pkg::POS_W-1:0]   mem_pos_m1;
   logic        [bmh_pkg::ADDR_W-1:0]  mem_addr;
   logic signed [bmh_pkg::KEY_W-1:0]   mem_wdata;

   // tree neighbors of the current position
   assign left_w     = {here_ff, 1'b0};
   assign left_pos   = left_w[bmh_pkg::POS_W-1:0];
   assign right_pos  = left_pos + bmh_pkg::POS_W'(1);
   assign parent_pos = here_ff >> 1;
   assign right_gt   = rdata_ff > ckey_ff;
   assign best_key   = right_gt ? rdata_ff : ckey_ff;
   assign best_pos   = right_gt ? right_pos : left_pos;

   always_comb begin
      sts.is_insert   = (kind_ff == bmh_pkg::REQ_INSERT);
      sts.full        = (cnt_ff == bmh_pkg::POS_W'(bmh_pkg::DEPTH));
      sts.bad         = (cnt_ff == '0) || (pos_ff == '0)
                        || (bmh_pkg::CMP_W'(pos_ff) > bmh_pkg::CMP_W'(cnt_ff));
      sts.del_last    = (bmh_pkg::CMP_W'(pos_ff) == bmh_pkg::CMP_W'(cnt_ff));
      sts.here_root   = (here_ff == bmh_pkg::POS_W'(1));
      sts.no_child    = left_w > {1'b0, cnt_ff};
      sts.has_right   = left_w < {1'b0, cnt_ff};
      sts.key_gt_rd   = key_ff > rdata_ff;
      sts.rd_gt_key   = rdata_ff > key_ff;
      sts.best_gt_key = best_key > key_ff;
   end

   // single memory port: one read or one write per cycle
   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_pos   = here_ff;
      mem_wdata = key_ff;
      if (cmd.start_del) begin
         mem_re  = 1'b1;
         mem_pos = cnt_ff;
      end else if (cmd.rd_parent) begin
         mem_re  = 1'b1;
         mem_pos = parent_pos;
      end else if (cmd.rd_left) begin
         mem_re  = 1'b1;
         mem_pos = left_pos;
      end else if (cmd.rd_right) begin
         mem_re  = 1'b1;
         mem_pos = right_pos;
      end else if (cmd.wr_key_here) begin
         mem_we = 1'b1;
      end else if (cmd.up_move || cmd.dn_move_left) begin
         mem_we    = 1'b1;
         mem_wdata = rdata_ff;
      end else if (cmd.dn_move_best) begin
         mem_we    = 1'b1;
         mem_wdata = best_key;
      end
   end

   assign mem_pos_m1 = mem_pos - bmh_pkg::POS_W'(1);
   assign mem_addr   = mem_pos_m1[bmh_pkg::ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) heap_mem[mem_addr] <= mem_wdata;
      if (mem_re) rdata_ff <= heap_mem[mem_addr];
   end

   always_comb begin
      key_in     = key_ff;
      cnt_in     = cnt_ff;
      here_in    = here_ff;
      settled_in = settled_ff;
      status_in  = status_ff;
      if (cmd.capture) key_in = req_key;
      if (cmd.load_key) key_in = rdata_ff;
      if (cmd.set_full) begin
         status_in  = bmh_pkg::ST_FULL;
         settled_in = '0;
      end
      if (cmd.set_bad) begin
         status_in  = bmh_pkg::ST_BAD;
         settled_in = '0;
      end
      if (cmd.drop_last || cmd.start_del) begin
         status_in  = bmh_pkg::ST_OK;
         settled_in = '0;
         cnt_in     = cnt_ff - bmh_pkg::POS_W'(1);
         here_in    = bmh_pkg::POS_W'(pos_ff);
      end
      if (cmd.start_ins) begin
         status_in  = bmh_pkg::ST_OK;
         settled_in = '0;
         cnt_in     = cnt_ff + bmh_pkg::POS_W'(1);
         here_in    = cnt_ff + bmh_pkg::POS_W'(1);
      end
      if (cmd.up_move) here_in = parent_pos;
      if (cmd.dn_move_left) here_in = left_pos;
      if (cmd.dn_move_best) here_in = best_pos;
      if (cmd.wr_key_here) settled_in = here_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         status_ff  <= bmh_pkg::ST_OK;
         settled_ff <= '0;
      end else begin
         cnt_ff     <= cnt_in;
         status_ff  <= status_in;
         settled_ff <= settled_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      here_ff <= here_in;
      if (cmd.capture) begin
         kind_ff <= req_kind;
         pos_ff  <= req_pos;
      end
      if (cmd.save_left) ckey_ff <= rdata_ff;
      // mirror of position 1 so the root needs no memory read
      if (mem_we && (mem_pos == bmh_pkg::POS_W'(1))) root_ff <= mem_wdata;
   end

   assign rsp_status    = status_ff;
   assign rsp_final_pos = bmh_pkg::FIELD_W'(settled_ff);
   assign rsp_count     = bmh_pkg::FIELD_W'(cnt_ff);
   assign rsp_root      = (cnt_ff == '0) ? '0 : root_ff;

   // count moves by one step at a time
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != $past(cnt_ff)) |->
      ((cnt_ff == $past(cnt_ff) + bmh_pkg::POS_W'(1))
       || (cnt_ff == $past(cnt_ff) - bmh_pkg::POS_W'(1))))
      else $error("heap count jumped");

   a_full_cnt: assert property (@(posedge clock) disable iff (reset)
      (status_ff == bmh_pkg::ST_FULL) |-> (cnt_ff == bmh_pkg::POS_W'(bmh_pkg::DEPTH)))
      else $error("full status with room left");

   a_err_pos: assert property (@(posedge clock) disable iff (reset)
      (status_ff != bmh_pkg::ST_OK) |-> (settled_ff == '0))
      else $error("error result with a position");

   // writes stay inside the live part of the heap
   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((mem_pos != '0) && (mem_pos <= cnt_ff)))
      else $error("heap write outside positions in use");

endmodule
